>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the segment intersection block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define SIJ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that does not depend on reset
`define SIJ_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> src/sij_pkg.sv
// ----------------------------------------------------------------------------
// sij_pkg
// Types and constants shared by the segment intersection modules.
// ----------------------------------------------------------------------------
package sij_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TOL_W = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

  typedef enum logic [1:0] {
    JC_END   = 2'd0,
    JC_TEE   = 2'd1,
    JC_CROSS = 2'd2
  } joint_class_t;

  typedef struct packed {
    logic valid;
    logic fail;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

>>> src/sij_front.sv
// ----------------------------------------------------------------------------
// sij_front
// Cramer terms, numerator products and division setup, four stages.
// ----------------------------------------------------------------------------
module sij_front #(
  parameter int COORD_BITS = sij_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_BITS-1:0]   x1,
  input  logic signed [COORD_BITS-1:0]   y1,
  input  logic signed [COORD_BITS-1:0]   x2,
  input  logic signed [COORD_BITS-1:0]   y2,
  input  logic signed [COORD_BITS-1:0]   x3,
  input  logic signed [COORD_BITS-1:0]   y3,
  input  logic signed [COORD_BITS-1:0]   x4,
  input  logic signed [COORD_BITS-1:0]   y4,
  output sij_pkg::ctl_t                  ctl,
  output logic [3*COORD_BITS+3:0]        rx,
  output logic [3*COORD_BITS+3:0]        ry,
  output logic [2*COORD_BITS+2:0]        d2,
  output logic [8*COORD_BITS-1:0]        side
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2*C + 2;
  localparam int NW = 2*C + 3;
  localparam int MW = 2*C + 2;
  localparam int DW = 2*C + 3;
  localparam int QB = C + 1;
  localparam int RW = DW + QB;
  localparam int SW = 8*C;

  // stage 1
  logic signed [C:0]    d12x, d12y, d34x, d34y, d13x, d13y;
  logic signed [PW-1:0] s1_den_a, s1_den_b, s1_num_a, s1_num_b;
  logic [SW-1:0]        s1_side;
  logic                 s1_valid;

  assign d12x = (C+1)'(x1) - (C+1)'(x2);
  assign d12y = (C+1)'(y1) - (C+1)'(y2);
  assign d34x = (C+1)'(x3) - (C+1)'(x4);
  assign d34y = (C+1)'(y3) - (C+1)'(y4);
  assign d13x = (C+1)'(x1) - (C+1)'(x3);
  assign d13y = (C+1)'(y1) - (C+1)'(y3);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_den_a <= d12x * d34y;
      s1_den_b <= d12y * d34x;
      s1_num_a <= d13x * d34y;
      s1_num_b <= d13y * d34x;
      s1_side  <= {y4, x4, y3, x3, y2, x2, y1, x1};
    end
  end

  // stage 2
  logic signed [NW-1:0] den, num;
  logic signed [C:0]    dx, dy;
  logic signed [C-1:0]  c_x1, c_y1, c_x2, c_y2;
  logic [MW-1:0]        s2_den_abs, s2_num_abs;
  logic                 s2_den_neg, s2_num_neg, s2_den_zero;
  logic [C:0]           s2_dx_abs, s2_dy_abs;
  logic                 s2_dx_neg, s2_dy_neg;
  logic [SW-1:0]        s2_side;
  logic                 s2_valid;

  assign c_x1 = s1_side[C-1:0];
  assign c_y1 = s1_side[2*C-1:C];
  assign c_x2 = s1_side[3*C-1:2*C];
  assign c_y2 = s1_side[4*C-1:3*C];
  assign den  = NW'(s1_den_a) - NW'(s1_den_b);
  assign num  = NW'(s1_num_a) - NW'(s1_num_b);
  assign dx   = (C+1)'(c_x2) - (C+1)'(c_x1);
  assign dy   = (C+1)'(c_y2) - (C+1)'(c_y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_den_neg  <= den[NW-1];
      s2_den_abs  <= MW'(den[NW-1] ? -den : den);
      s2_den_zero <= (den == '0);
      s2_num_neg  <= num[NW-1];
      s2_num_abs  <= MW'(num[NW-1] ? -num : num);
      s2_dx_neg   <= dx[C];
      s2_dx_abs   <= dx[C] ? -dx : dx;
      s2_dy_neg   <= dy[C];
      s2_dy_abs   <= dy[C] ? -dy : dy;
      s2_side     <= s1_side;
    end
  end

  // stage 3: numerator times segment delta, split in two partial products
  logic [PW-1:0] s3_mxl, s3_mxh, s3_myl, s3_myh;
  logic [MW-1:0] s3_den_abs;
  logic          s3_den_zero, s3_neg_x, s3_neg_y, s3_valid;
  logic [SW-1:0] s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_mxl      <= PW'(s2_num_abs[C:0]) * PW'(s2_dx_abs);
      s3_mxh      <= PW'(s2_num_abs[MW-1:C+1]) * PW'(s2_dx_abs);
      s3_myl      <= PW'(s2_num_abs[C:0]) * PW'(s2_dy_abs);
      s3_myh      <= PW'(s2_num_abs[MW-1:C+1]) * PW'(s2_dy_abs);
      s3_den_abs  <= s2_den_abs;
      s3_den_zero <= s2_den_zero;
      s3_neg_x    <= s2_num_neg ^ s2_dx_neg ^ s2_den_neg;
      s3_neg_y    <= s2_num_neg ^ s2_dy_neg ^ s2_den_neg;
      s3_side     <= s2_side;
    end
  end

  // stage 4: rounded-division operands, 2N + |den| over 2|den|
  logic [RW-1:0] nx, ny, r0x, r0y, lim;
  logic [DW-1:0] d2_c;

  assign nx   = (RW'(s3_mxh) << (C+1)) + RW'(s3_mxl);
  assign ny   = (RW'(s3_myh) << (C+1)) + RW'(s3_myl);
  assign r0x  = (nx << 1) + RW'(s3_den_abs);
  assign r0y  = (ny << 1) + RW'(s3_den_abs);
  assign d2_c = DW'(s3_den_abs) << 1;
  assign lim  = RW'(d2_c) << QB;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= s3_valid;
    end
    if (en) begin
      ctl.fail  <= s3_den_zero || (r0x >= lim) || (r0y >= lim);
      ctl.neg_x <= s3_neg_x;
      ctl.neg_y <= s3_neg_y;
      rx        <= r0x;
      ry        <= r0y;
      d2        <= d2_c;
      side      <= s3_side;
    end
  end

endmodule

>>> src/sij_div_cell.sv
// ----------------------------------------------------------------------------
// sij_div_cell
// One restoring-division step for the x and y quotients, one bit per cell.
// ----------------------------------------------------------------------------
module sij_div_cell #(
  parameter int RW   = 76,
  parameter int DW   = 51,
  parameter int QB   = 25,
  parameter int SW   = 192,
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  sij_pkg::ctl_t   ctl_in,
  input  logic [RW-1:0]   rx_in,
  input  logic [RW-1:0]   ry_in,
  input  logic [QB-1:0]   qx_in,
  input  logic [QB-1:0]   qy_in,
  input  logic [DW-1:0]   d2_in,
  input  logic [SW-1:0]   side_in,
  output sij_pkg::ctl_t   ctl_out,
  output logic [RW-1:0]   rx_out,
  output logic [RW-1:0]   ry_out,
  output logic [QB-1:0]   qx_out,
  output logic [QB-1:0]   qy_out,
  output logic [DW-1:0]   d2_out,
  output logic [SW-1:0]   side_out
);

  logic [RW-1:0] dsh;
  logic          ge_x, ge_y;

  assign dsh  = RW'(d2_in) << STEP;
  assign ge_x = rx_in >= dsh;
  assign ge_y = ry_in >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.fail  <= ctl_in.fail;
      ctl_out.neg_x <= ctl_in.neg_x;
      ctl_out.neg_y <= ctl_in.neg_y;
      rx_out        <= ge_x ? rx_in - dsh : rx_in;
      ry_out        <= ge_y ? ry_in - dsh : ry_in;
      qx_out        <= qx_in | (QB'(ge_x) << STEP);
      qy_out        <= qy_in | (QB'(ge_y) << STEP);
      d2_out        <= d2_in;
      side_out      <= side_in;
    end
  end

endmodule

>>> src/sij_back.sv
// ----------------------------------------------------------------------------
// sij_back
// Intersection point, box test, joint class and saturation; output register.
// ----------------------------------------------------------------------------
module sij_back #(
  parameter int COORD_BITS = sij_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic [sij_pkg::TOL_W-1:0]           tol,
  input  sij_pkg::ctl_t                       ctl,
  input  logic [COORD_BITS:0]                 qx,
  input  logic [COORD_BITS:0]                 qy,
  input  logic [8*COORD_BITS-1:0]             side,
  output logic                                out_valid,
  output logic                                hit,
  output logic signed [COORD_BITS-1:0]        cross_x,
  output logic signed [COORD_BITS-1:0]        cross_y,
  output logic [1:0]                          joint_class
);

  localparam int C  = COORD_BITS;
  localparam int XW = C + 3;

  function automatic logic near(input logic signed [XW-1:0] p,
                                input logic signed [XW-1:0] e,
                                input logic [sij_pkg::TOL_W-1:0] t);
    logic signed [XW:0] d;
    logic [XW:0]        ad;
    d  = (XW+1)'(p) - (XW+1)'(e);
    ad = d[XW] ? -d : d;
    return ad < (XW+1)'(t);
  endfunction

  function automatic logic in_box(input logic signed [XW-1:0] v,
                                  input logic signed [XW-1:0] a,
                                  input logic signed [XW-1:0] b,
                                  input logic signed [XW-1:0] t);
    logic signed [XW-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (v >= lo - t) && (v <= hi + t);
  endfunction

  function automatic logic signed [C-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] cmax, cmin;
    cmax = XW'((1 <<< (C-1)) - 1);
    cmin = -cmax - XW'(1);
    if (v > cmax) begin
      return C'(cmax);
    end else if (v < cmin) begin
      return C'(cmin);
    end
    return C'(v);
  endfunction

  logic signed [XW-1:0] x1, y1, x2, y2, x3, y3, x4, y4, tw, qxs, qys, px, py;
  logic                 ok, ea, eb;
  sij_pkg::joint_class_t jc;

  assign x1  = XW'($signed(side[C-1:0]));
  assign y1  = XW'($signed(side[2*C-1:C]));
  assign x2  = XW'($signed(side[3*C-1:2*C]));
  assign y2  = XW'($signed(side[4*C-1:3*C]));
  assign x3  = XW'($signed(side[5*C-1:4*C]));
  assign y3  = XW'($signed(side[6*C-1:5*C]));
  assign x4  = XW'($signed(side[7*C-1:6*C]));
  assign y4  = XW'($signed(side[8*C-1:7*C]));
  assign tw  = $signed(XW'(tol));
  assign qxs = ctl.neg_x ? -$signed(XW'(qx)) : $signed(XW'(qx));
  assign qys = ctl.neg_y ? -$signed(XW'(qy)) : $signed(XW'(qy));
  assign px  = x1 + qxs;
  assign py  = y1 + qys;

  assign ok = !ctl.fail && in_box(px, x1, x2, tw) && in_box(py, y1, y2, tw) &&
              in_box(px, x3, x4, tw) && in_box(py, y3, y4, tw);
  assign ea = (near(px, x1, tol) && near(py, y1, tol)) ||
              (near(px, x2, tol) && near(py, y2, tol));
  assign eb = (near(px, x3, tol) && near(py, y3, tol)) ||
              (near(px, x4, tol) && near(py, y4, tol));

  always_comb begin
    if (ea && eb) begin
      jc = sij_pkg::JC_END;
    end else if (ea || eb) begin
      jc = sij_pkg::JC_TEE;
    end else begin
      jc = sij_pkg::JC_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl.valid;
    end
    if (en) begin
      hit         <= ok;
      cross_x     <= ok ? sat(px) : '0;
      cross_y     <= ok ? sat(py) : '0;
      joint_class <= ok ? jc : sij_pkg::JC_END;
    end
  end

endmodule

>>> src/segment_intersection_join_classify.sv
// Throughput: one segment pair per cycle, except while the output stalls the
// pipe; one quotient bit per division cell.
// The whole pipe advances when the output register is empty or being taken.
// Reset: synchronous, clears all valid bits and sets tolerance to 1.
// ----------------------------------------------------------------------------
// segment_intersection_join_classify
// 2D segment intersection with rounded point and end/tee/cross classing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_join_classify #(
  parameter int COORD_BITS = sij_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sij_pkg::TOL_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  a_start_x,
  input  logic signed [COORD_BITS-1:0]  a_start_y,
  input  logic signed [COORD_BITS-1:0]  a_end_x,
  input  logic signed [COORD_BITS-1:0]  a_end_y,
  input  logic signed [COORD_BITS-1:0]  b_start_x,
  input  logic signed [COORD_BITS-1:0]  b_start_y,
  input  logic signed [COORD_BITS-1:0]  b_end_x,
  input  logic signed [COORD_BITS-1:0]  b_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic signed [COORD_BITS-1:0]  cross_x,
  output logic signed [COORD_BITS-1:0]  cross_y,
  output logic [1:0]                    joint_class
);

  localparam int C  = COORD_BITS;
  localparam int DW = 2*C + 3;
  localparam int QB = C + 1;
  localparam int RW = DW + QB;
  localparam int SW = 8*C;

  logic                      en;
  logic [sij_pkg::TOL_W-1:0] tolerance;

  sij_pkg::ctl_t ctl [QB+1];
  logic [RW-1:0] rx [QB+1];
  logic [RW-1:0] ry [QB+1];
  logic [QB-1:0] qx [QB+1];
  logic [QB-1:0] qy [QB+1];
  logic [DW-1:0] d2 [QB+1];
  logic [SW-1:0] side [QB+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= sij_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_data;
    end
  end

  sij_front #(.COORD_BITS(C)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .x1       (a_start_x),
    .y1       (a_start_y),
    .x2       (a_end_x),
    .y2       (a_end_y),
    .x3       (b_start_x),
    .y3       (b_start_y),
    .x4       (b_end_x),
    .y4       (b_end_y),
    .ctl      (ctl[0]),
    .rx       (rx[0]),
    .ry       (ry[0]),
    .d2       (d2[0]),
    .side     (side[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    sij_div_cell #(
      .RW   (RW),
      .DW   (DW),
      .QB   (QB),
      .SW   (SW),
      .STEP (QB - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[k]),
      .rx_in    (rx[k]),
      .ry_in    (ry[k]),
      .qx_in    (qx[k]),
      .qy_in    (qy[k]),
      .d2_in    (d2[k]),
      .side_in  (side[k]),
      .ctl_out  (ctl[k+1]),
      .rx_out   (rx[k+1]),
      .ry_out   (ry[k+1]),
      .qx_out   (qx[k+1]),
      .qy_out   (qy[k+1]),
      .d2_out   (d2[k+1]),
      .side_out (side[k+1])
    );
  end

  sij_back #(.COORD_BITS(C)) u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .tol         (tolerance),
    .ctl         (ctl[QB]),
    .qx          (qx[QB]),
    .qy          (qy[QB]),
    .side        (side[QB]),
    .out_valid   (out_valid),
    .hit         (hit),
    .cross_x     (cross_x),
    .cross_y     (cross_y),
    .joint_class (joint_class)
  );

  `SIJ_ASSERT_IMPL(a_stall_only_when_full, clk, rst, !in_ready, out_valid && !out_ready)
  `SIJ_ASSERT_IMPL(a_miss_is_zero, clk, rst, out_valid && !hit,
                   cross_x == '0 && cross_y == '0 && joint_class == sij_pkg::JC_END)
  `SIJ_ASSERT_IMPL(a_class_legal, clk, rst, out_valid && hit,
                   joint_class == sij_pkg::JC_END || joint_class == sij_pkg::JC_TEE ||
                   joint_class == sij_pkg::JC_CROSS)
  `SIJ_ASSERT_ALWAYS(a_reset_clears, clk, rst, ##1 !out_valid)

endmodule

>>> tb/tb_segment_intersection_join_classify.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_join_classify
// Streams segment pairs through the intersection classifier and checks every
// result field against an in-bench integer predictor, across several tolerance
// settings and varied idle/stall patterns on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_intersection_join_classify;

  localparam int CW = 24;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct {
    crd_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct {
    logic hit;
    crd_t x, y;
    sij_pkg::joint_class_t jc;
  } joint_t;

  class joint_scoreboard;
    joint_t pending[$];
    longint tol = longint'(sij_pkg::TOL_RESET);
    int errors, seen, hits;
    int cls_cnt[3];

    function automatic longint round_quot(logic signed [127:0] n, logic signed [127:0] d);
      logic [127:0] un, ud, q, r;
      logic neg;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = un / ud;
      r = un % ud;
      if ((r << 1) >= ud) q = q + 1;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic bit in_box(longint v, longint a, longint b);
      longint lo, hi;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      return v >= lo - tol && v <= hi + tol;
    endfunction

    function automatic bit near(longint px, longint py, longint ex, longint ey);
      longint dx, dy;
      dx = px > ex ? px - ex : ex - px;
      dy = py > ey ? py - ey : ey - py;
      return dx < tol && dy < tol;
    endfunction

    function automatic void note_request(seg_pair_t s);
      longint x1, y1, x2, y2, x3, y3, x4, y4, px, py;
      logic signed [127:0] den, num;
      bit ea, eb;
      joint_t e;
      x1 = s.ax0; y1 = s.ay0; x2 = s.ax1; y2 = s.ay1;
      x3 = s.bx0; y3 = s.by0; x4 = s.bx1; y4 = s.by1;
      e = '{hit: 0, x: '0, y: '0, jc: sij_pkg::JC_END};
      den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
      if (den != 0) begin
        num = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
        px = x1 + round_quot(num * (x2 - x1), den);
        py = y1 + round_quot(num * (y2 - y1), den);
        if (in_box(px, x1, x2) && in_box(py, y1, y2) &&
            in_box(px, x3, x4) && in_box(py, y3, y4)) begin
          ea = near(px, py, x1, y1) || near(px, py, x2, y2);
          eb = near(px, py, x3, y3) || near(px, py, x4, y4);
          if (px > CMAX) px = CMAX;
          if (px < CMIN) px = CMIN;
          if (py > CMAX) py = CMAX;
          if (py < CMIN) py = CMIN;
          e.hit = 1;
          e.x = px[CW-1:0];
          e.y = py[CW-1:0];
          e.jc = (ea && eb) ? sij_pkg::JC_END :
                 ((ea || eb) ? sij_pkg::JC_TEE : sij_pkg::JC_CROSS);
        end
      end
      pending.insert(pending.size(), e);
    endfunction

    function automatic void check_result(joint_t a);
      joint_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0d x=%0d y=%0d class=%0d",
                 $time, a.hit, a.x, a.y, a.jc);
        errors++;
        return;
      end
      e = pending.pop_front();
      seen++;
      if (e.hit) begin
        hits++;
        cls_cnt[e.jc]++;
      end
      if (a.hit !== e.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, a.hit);
        errors++;
      end
      if (a.x !== e.x) begin
        $display("%0t: cross_x expected %0d actual %0d", $time, e.x, a.x);
        errors++;
      end
      if (a.y !== e.y) begin
        $display("%0t: cross_y expected %0d actual %0d", $time, e.y, a.y);
        errors++;
      end
      if (a.jc !== e.jc) begin
        $display("%0t: joint_class expected %0d actual %0d", $time, e.jc, a.jc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [sij_pkg::TOL_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  crd_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  crd_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic hit;
  crd_t cross_x, cross_y;
  logic [1:0] joint_class;

  joint_scoreboard sb = new();
  int snd_idle, rcv_idle;
  int hold_cycles;
  int cycles;

  always #10 clk = ~clk;

  segment_intersection_join_classify #(.COORD_BITS(CW)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
    .b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
    .cross_x(cross_x), .cross_y(cross_y), .joint_class(joint_class)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // result side; hold_cycles forces a long back-pressure stretch
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{hit: hit, x: cross_x, y: cross_y,
                        jc: sij_pkg::joint_class_t'(joint_class)});
    if (rst) begin
      out_ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_request(seg_pair_t s);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    a_start_x <= s.ax0; a_start_y <= s.ay0; a_end_x <= s.ax1; a_end_y <= s.ay1;
    b_start_x <= s.bx0; b_start_y <= s.by0; b_end_x <= s.bx1; b_end_y <= s.by1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(s);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_tolerance(int unsigned v);
    drain();
    cfg_we <= 1;
    cfg_data <= v[sij_pkg::TOL_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    sb.tol = longint'(v);
  endtask

  function automatic crd_t rnd_crd(int span);
    return crd_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic crd_t edge_crd();
    case ($urandom_range(4))
      0: return crd_t'(CMAX);
      1: return crd_t'(CMIN);
      2: return '0;
      3: return '1;
      default: return crd_t'(1);
    endcase
  endfunction

  function automatic seg_pair_t make_pair();
    seg_pair_t s;
    int dx, dy;
    s.ax0 = rnd_crd(1000); s.ay0 = rnd_crd(1000);
    s.ax1 = rnd_crd(1000); s.ay1 = rnd_crd(1000);
    s.bx0 = rnd_crd(1000); s.by0 = rnd_crd(1000);
    s.bx1 = rnd_crd(1000); s.by1 = rnd_crd(1000);
    case ($urandom_range(9))
      0, 1: begin
        s = '{crd_t'($urandom), crd_t'($urandom), crd_t'($urandom), crd_t'($urandom),
              crd_t'($urandom), crd_t'($urandom), crd_t'($urandom), crd_t'($urandom)};
      end
      2, 3: ;
      4: begin
        s.bx0 = s.ax1 + rnd_crd(2);
        s.by0 = s.ay1 + rnd_crd(2);
      end
      5: begin
        dx = $urandom_range(600) - 300;
        dy = $urandom_range(600) - 300;
        s.ax1 = crd_t'(s.ax0 + 2 * dx);
        s.ay1 = crd_t'(s.ay0 + 2 * dy);
        s.bx0 = crd_t'(s.ax0 + dx);
        s.by0 = crd_t'(s.ay0 + dy);
      end
      6: begin
        dx = $urandom_range(50);
        s.bx0 = crd_t'(s.ax0 + dx); s.by0 = crd_t'(s.ay0 + dx);
        s.bx1 = crd_t'(s.ax1 + dx); s.by1 = crd_t'(s.ay1 + dx);
      end
      7: begin
        if ($urandom_range(1)) begin
          s.ax1 = s.ax0; s.ay1 = s.ay0;
        end else begin
          s.bx1 = s.bx0; s.by1 = s.by0;
        end
      end
      8: begin
        s.ax0 = edge_crd(); s.ay0 = edge_crd(); s.ax1 = edge_crd(); s.ay1 = edge_crd();
        s.bx0 = edge_crd(); s.by0 = edge_crd(); s.bx1 = edge_crd(); s.by1 = edge_crd();
      end
      default: begin
        // near-parallel long segments
        s.ax0 = crd_t'(CMIN); s.ay0 = rnd_crd(3);
        s.ax1 = crd_t'(CMAX); s.ay1 = rnd_crd(3);
        s.bx0 = crd_t'(CMIN); s.by0 = crd_t'(rnd_crd(3) + 10);
        s.bx1 = crd_t'(CMAX); s.by1 = crd_t'(rnd_crd(3) + 10);
      end
    endcase
    return s;
  endfunction

  task automatic run_directed();
    crd_t mx, mn;
    mx = crd_t'(CMAX);
    mn = crd_t'(CMIN);
    send_request('{-100, -100, 100, 100, -100, 100, 100, -100});
    send_request('{0, 0, 100, 0, 50, 0, 50, 80});
    send_request('{0, 0, 100, 0, 100, 0, 100, 80});
    send_request('{0, 0, 100, 0, 0, 5, 100, 5});
    send_request('{0, 0, 100, 0, 20, 0, 150, 0});
    send_request('{7, 7, 7, 7, 0, 0, 10, 10});
    send_request('{0, 0, 3, 1, 5, -3, 6, 4});
    send_request('{0, 0, 100, 0, 101, 1, 101, 50});
    send_request('{0, 0, 100, 0, 50, 1, 50, 60});
    send_request('{mn, mn, mx, mx, mn, mx, mx, mn});
    send_request('{mx, mx, mx, mx, mx, mx, mx, mx});
    send_request('{mn, mn, mn, mn, mn, mn, mn, mn});
    send_request('{mn, 0, mx, 1, mn, 1, mx, 2});
    send_request('{crd_t'(mx - 10), 0, mx, 0, crd_t'(mx - 2), -4, mx, -2});
    send_request('{mn, 0, crd_t'(mn + 10), 0, crd_t'(mn + 2), -4, mn, -2});
    send_request('{mn, mn, mx, mx, mn, crd_t'(mn + 1), mx, mx});
    send_request('{0, 0, 10, 10, 3, 4, 3, 4});
  endtask

  task automatic run_phase(int unsigned tol, int s_idle, int r_idle, int n, bit squeeze);
    set_tolerance(tol);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    run_directed();
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == 20) hold_cycles = 300;
      send_request(make_pair());
    end
  endtask

  initial begin
    cycles = 0;
    hold_cycles = 0;
    snd_idle = 0;
    rcv_idle = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    snd_idle = 26;
    rcv_idle = 56;
    run_directed();
    for (int i = 0; i < 80; i++) send_request(make_pair());
    run_phase(0, 56, 26, 80, 1);
    run_phase(255, 0, 0, 80, 0);
    run_phase($urandom_range(2, 254), 26, 56, 60, 0);
    run_phase(1, 0, 0, 60, 1);
    drain();
    $display("checked %0d results, %0d hits (end %0d, tee %0d, cross %0d)",
             sb.seen, sb.hits, sb.cls_cnt[0], sb.cls_cnt[1], sb.cls_cnt[2]);
    $display("tolerances covered: reset, 0, 255, random; idle and back-pressure mixes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
